@@ rtl/i8080_pkg.sv @@
// Package for the 8080-style instruction executor.
// Holds widths, action and status codes, flag positions and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package i8080_pkg;
  localparam int AddrBits = 16;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_EXEC  = 2'd2,
    ACT_IRQ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HALTED = 2'd1,
    ST_UNIMPL = 2'd2
  } status_e;

  localparam int FlS  = 7;
  localparam int FlZ  = 6;
  localparam int FlAc = 4;
  localparam int FlP  = 2;
  localparam int FlCy = 0;

  typedef struct packed {
    logic                we;
    logic [AddrBits-1:0] addr;
    logic [7:0]          wdata;
  } mem_req_t;

  function automatic logic [7:0] szp(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r = f;
    r[FlS] = v[7];
    r[FlZ] = (v == 8'h00);
    r[FlP] = ~(^v);
    return r;
  endfunction

  function automatic logic cond_met(input logic [7:0] f, input logic [2:0] cc);
    logic c;
    case (cc[2:1])
      2'd0:    c = f[FlZ];
      2'd1:    c = f[FlCy];
      2'd2:    c = f[FlP];
      default: c = f[FlS];
    endcase
    return cc[0] ? c : ~c;
  endfunction
endpackage
`default_nettype wire

@@ rtl/i8080_mem.sv @@
// Byte memory of the 8080-style executor: one port, read data registered.
// Depends on i8080_pkg.
`timescale 1ns / 1ps
`default_nettype none
module i8080_mem import i8080_pkg::*; (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.addr];
  end
endmodule
`default_nettype wire

@@ rtl/cpu_8080_instruction_executor.sv @@
// Top level of the 8080-style executor: sequencer, registers and ALU around one memory.
// Depends on i8080_pkg and i8080_mem.
//
//  channel  | handshake         | payload
//  command  | start_i / busy_o  | action_i address_i write_data_i irq_number_i
//  result   | done_o (strobe)   | status_o read_data_o ... irq_enabled_o
//
// Memory bytes are accessed one at a time on the single memory port; an instruction
// fetches its opcode, two following bytes and the byte at HL, then makes its data
// byte accesses, if any, before it executes; XTHL makes four such accesses.
// Reset clears the CPU registers and flags but not read_data_o; memory content is undefined until written.
// The result strobe lasts one cycle; a new command may be taken at the edge ending it.
`timescale 1ns / 1ps
`default_nettype none
module cpu_8080_instruction_executor import i8080_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [2:0]  irq_number_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       read_data_o,
  output logic [15:0]      prog_counter_o,
  output logic [15:0]      stack_pointer_o,
  output logic [7:0]       accum_o,
  output logic [15:0]      pair_bc_o,
  output logic [15:0]      pair_de_o,
  output logic [15:0]      pair_hl_o,
  output logic [7:0]       flag_byte_o,
  output logic             irq_enabled_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_F0    = 4'd1;
  localparam logic [3:0] S_F1    = 4'd2;
  localparam logic [3:0] S_F2    = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_MEM   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;
  localparam logic [3:0] S_MRD   = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, e_q, e_d, h_q, h_d, l_q, l_d;
  logic [7:0]  f_q, f_d;
  logic [15:0] pc_q, pc_d, sp_q, sp_d;
  logic        ie_q, ie_d, hlt_q, hlt_d;
  logic [7:0]  op_q, op_d, b1_q, b1_d, b2_q, b2_d;
  logic [1:0]  act_q, act_d;
  logic [2:0]  irq_q, irq_d;
  logic [1:0]  st_q, st_d;
  logic [7:0]  rd_q, rd_d;
  // memory sub-operation sequencer: up to four byte accesses
  logic [2:0]  step_q, step_d;
  logic [7:0]  t0_q, t0_d, t1_q, t1_d;
  logic        done_q, done_d;
  mem_req_t    req;
  logic [7:0]  mrd;

  i8080_mem u_mem (.clk_i(clk_i), .req_i(req), .rdata_o(mrd));

  function automatic logic [AddrBits-1:0] ma(input logic [15:0] a);
    return a[AddrBits-1:0];
  endfunction

  logic [15:0] hl, bc, de, imm;
  logic [2:0]  lo, mid;
  logic [1:0]  rp;
  assign hl  = {h_q, l_q};
  assign bc  = {b_q, c_q};
  assign de  = {d_q, e_q};
  assign imm = {b2_q, b1_q};
  assign lo  = op_q[2:0];
  assign mid = op_q[5:3];
  assign rp  = op_q[5:4];

  function automatic logic [7:0] rsel(input logic [2:0] c, input logic [7:0] bb,
      input logic [7:0] cc, input logic [7:0] dd, input logic [7:0] ee,
      input logic [7:0] hh, input logic [7:0] ll, input logic [7:0] aa,
      input logic [7:0] mm);
    logic [7:0] v;
    case (c)
      3'd0: v = bb; 3'd1: v = cc; 3'd2: v = dd; 3'd3: v = ee;
      3'd4: v = hh; 3'd5: v = ll; 3'd6: v = mm;
      default: v = aa;
    endcase
    return v;
  endfunction

  // does the instruction need a memory-held operand M (via HL) before executing
  logic need_m;
  always_comb begin
    need_m = 1'b0;
    if (op_q >= 8'h40 && op_q < 8'hc0 && op_q != 8'h76) begin
      need_m = (lo == 3'd6);
    end else if (op_q < 8'h40 && (lo == 3'd4 || lo == 3'd5)) begin
      need_m = (mid == 3'd6);
    end
  end

  logic [7:0] src, alu_in, alu_res, fl;
  logic [8:0] sum;
  logic       wr_a;

  always_comb begin
    alu_in  = 8'h00;
    alu_res = a_q;
    fl      = f_q;
    sum     = 9'd0;
    wr_a    = 1'b1;
    src = rsel(lo, b_q, c_q, d_q, e_q, h_q, l_q, a_q, t0_q);
    alu_in = (op_q[7:6] == 2'b11) ? b1_q : src;
    case (mid)
      3'd0, 3'd1: begin
        sum = {1'b0, a_q} + {1'b0, alu_in} + {8'd0, mid[0] & f_q[FlCy]};
        alu_res = sum[7:0];
        fl = szp(f_q, sum[7:0]);
        fl[FlCy] = sum[8];
      end
      3'd2, 3'd3, 3'd7: begin
        sum = {1'b0, a_q} - {1'b0, alu_in} - {8'd0, (mid == 3'd3) & f_q[FlCy]};
        alu_res = sum[7:0];
        fl = szp(f_q, sum[7:0]);
        fl[FlCy] = sum[8];
        wr_a = (mid != 3'd7);
      end
      default: begin
        case (mid)
          3'd4:    alu_res = a_q & alu_in;
          3'd5:    alu_res = a_q ^ alu_in;
          default: alu_res = a_q | alu_in;
        endcase
        fl = szp(f_q, alu_res);
        fl[FlCy] = 1'b0;
        fl[FlAc] = 1'b0;
      end
    endcase
  end

  function automatic logic [15:0] pget(input logic [1:0] p, input logic [15:0] x0,
      input logic [15:0] x1, input logic [15:0] x2, input logic [15:0] x3);
    logic [15:0] v;
    case (p)
      2'd0: v = x0; 2'd1: v = x1; 2'd2: v = x2;
      default: v = x3;
    endcase
    return v;
  endfunction

  logic [15:0] prp;
  logic [16:0] dad;
  assign prp = pget(rp, bc, de, hl, sp_q);
  assign dad = {1'b0, hl} + {1'b0, prp};

  // memory plan for the decoded instruction
  // kind: 0 none, 1 write bytes, 2 read bytes, 3 xthl
  logic [1:0]  k_kind;
  logic [2:0]  k_n;
  logic [15:0] k_a0, k_a1;
  logic [7:0]  k_w0, k_w1;
  logic        is_push, is_pop;
  logic [15:0] push_v;
  logic        ccond;
  assign ccond = cond_met(f_q, mid);

  always_comb begin
    k_kind = 2'd0; k_n = 3'd0; k_a0 = 16'd0; k_a1 = 16'd0; k_w0 = 8'h00; k_w1 = 8'h00;
    is_push = 1'b0; is_pop = 1'b0; push_v = 16'd0;
    if (op_q < 8'h40) begin
      if (lo == 3'd2) begin
        case (rp)
          2'd0, 2'd1: begin
            k_kind = op_q[3] ? 2'd2 : 2'd1; k_n = 3'd1; k_a0 = prp; k_w0 = a_q;
          end
          2'd2: begin
            k_kind = op_q[3] ? 2'd2 : 2'd1; k_n = 3'd2; k_a0 = imm; k_a1 = imm + 16'd1;
            k_w0 = l_q; k_w1 = h_q;
          end
          default: begin
            k_kind = op_q[3] ? 2'd2 : 2'd1; k_n = 3'd1; k_a0 = imm; k_w0 = a_q;
          end
        endcase
      end
    end else if (op_q >= 8'hc0) begin
      case (lo)
        3'd0: is_pop = ccond;
        3'd1: is_pop = ~op_q[3] | (rp == 2'd0);
        3'd3: if (mid == 3'd4) begin
          k_kind = 2'd3; k_n = 3'd4; k_a0 = sp_q; k_a1 = sp_q + 16'd1;
        end
        3'd4: begin is_push = ccond; push_v = pc_q + 16'd3; end
        3'd5: begin
          if (op_q[3]) begin is_push = (rp == 2'd0); push_v = pc_q + 16'd3; end
          else begin
            is_push = 1'b1;
            push_v = (rp == 2'd3) ? {a_q, f_q | 8'h02} : prp;
          end
        end
        3'd7: begin is_push = 1'b1; push_v = pc_q + 16'd1; end
        default: ;
      endcase
      if (is_push) begin
        k_kind = 2'd1; k_n = 3'd2; k_a0 = sp_q - 16'd1; k_a1 = sp_q - 16'd2;
        k_w0 = push_v[15:8]; k_w1 = push_v[7:0];
      end
      if (is_pop) begin
        k_kind = 2'd2; k_n = 3'd2; k_a0 = sp_q; k_a1 = sp_q + 16'd1;
      end
    end
  end

  logic [1:0]  kind_q, kind_d;
  logic [7:0]  mres;
  logic        mwr;

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    f_d = f_q; pc_d = pc_q; sp_d = sp_q; ie_d = ie_q; hlt_d = hlt_q;
    op_d = op_q; b1_d = b1_q; b2_d = b2_q; act_d = act_q;
    irq_d = irq_q; st_d = st_q; rd_d = rd_q; step_d = step_q; t0_d = t0_q; t1_d = t1_q;
    kind_d = kind_q; done_d = 1'b0;
    req = '{we: 1'b0, addr: ma(pc_q), wdata: 8'h00};
    mres = 8'h00; mwr = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d = action_i; irq_d = irq_number_i;
          rd_d = 8'h00; st_d = ST_OK;
          unique case (action_e'(action_i))
            ACT_WRITE: begin
              req = '{we: 1'b1, addr: ma(address_i), wdata: write_data_i};
              state_d = S_DONE;
            end
            ACT_READ: begin
              req = '{we: 1'b0, addr: ma(address_i), wdata: 8'h00};
              state_d = S_RD;
            end
            ACT_EXEC: begin
              if (hlt_q) state_d = S_DONE;
              else begin
                req.addr = ma(pc_q);
                state_d = S_F0;
              end
            end
            default: begin
              if (ie_q) begin
                req = '{we: 1'b1, addr: ma(sp_q - 16'd1), wdata: pc_q[15:8]};
                step_d = 3'd1;
                state_d = S_MEM;
                kind_d = 2'd0;
              end else state_d = S_DONE;
            end
          endcase
        end
      end
      S_RD: begin
        rd_d = mrd;
        state_d = S_DONE;
      end
      S_F0: begin
        op_d = mrd; req.addr = ma(pc_q + 16'd1); state_d = S_F1;
      end
      S_F1: begin
        b1_d = mrd; req.addr = ma(pc_q + 16'd2); state_d = S_F2;
      end
      S_F2: begin
        b2_d = mrd; req.addr = ma(hl); state_d = S_MRD;
      end
      S_MRD: begin
        t0_d = mrd;
        step_d = 3'd0;
        kind_d = k_kind;
        state_d = (k_kind == 2'd0) ? S_DEC : S_MEM;
        if (need_m) state_d = S_DEC;
      end
      S_MEM: begin
        // sequence of byte accesses; reads land in the cycle after their request
        if (act_q == ACT_IRQ) begin
          unique case (step_q)
            3'd1: begin
              req = '{we: 1'b1, addr: ma(sp_q - 16'd2), wdata: pc_q[7:0]};
              sp_d = sp_q - 16'd2; pc_d = {10'd0, irq_q, 3'd0};
              ie_d = 1'b0; hlt_d = 1'b0; state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end else begin
          unique case (kind_q)
            2'd1: begin
              if (step_q == 3'd0) req = '{we: 1'b1, addr: ma(k_a0), wdata: k_w0};
              else req = '{we: 1'b1, addr: ma(k_a1), wdata: k_w1};
              step_d = step_q + 3'd1;
              if (step_q + 3'd1 == k_n) state_d = S_DEC;
            end
            2'd2: begin
              if (step_q == 3'd1) t0_d = mrd;
              if (step_q == 3'd2) t1_d = mrd;
              req.addr = (step_q == 3'd0) ? ma(k_a0) : ma(k_a1);
              step_d = step_q + 3'd1;
              if (step_q == k_n) state_d = S_DEC;
            end
            default: begin
              // exchange top of stack with HL
              unique case (step_q)
                3'd0: req.addr = ma(k_a0);
                3'd1: begin
                  t0_d = mrd; req = '{we: 1'b1, addr: ma(k_a0), wdata: l_q};
                end
                3'd2: req.addr = ma(k_a1);
                default: begin
                  t1_d = mrd; req = '{we: 1'b1, addr: ma(k_a1), wdata: h_q};
                  state_d = S_DEC;
                end
              endcase
              step_d = step_q + 3'd1;
            end
          endcase
        end
      end
      S_DEC: begin
        pc_d = pc_q + 16'd1;
        if (op_q == 8'h76) begin
          hlt_d = 1'b1;
        end else if (op_q >= 8'h40 && op_q < 8'h80) begin
          mres = src; mwr = 1'b1;
        end else if (op_q >= 8'h80 && op_q < 8'hc0) begin
          if (wr_a) a_d = alu_res;
          f_d = fl;
        end else if (op_q < 8'h40) begin
          unique case (lo)
            3'd0: ;
            3'd1: begin
              if (op_q[3]) begin
                f_d[FlCy] = dad[16]; h_d = dad[15:8]; l_d = dad[7:0];
              end else begin
                pc_d = pc_q + 16'd3;
                case (rp)
                  2'd0: begin b_d = b2_q; c_d = b1_q; end
                  2'd1: begin d_d = b2_q; e_d = b1_q; end
                  2'd2: begin h_d = b2_q; l_d = b1_q; end
                  default: sp_d = imm;
                endcase
              end
            end
            3'd2: begin
              if (rp[1]) pc_d = pc_q + 16'd3;
              if (op_q[3]) begin
                if (rp == 2'd2) begin l_d = t0_q; h_d = t1_q; end
                else a_d = t0_q;
              end
            end
            3'd3: begin
              case (rp)
                2'd0: {b_d, c_d} = op_q[3] ? bc - 16'd1 : bc + 16'd1;
                2'd1: {d_d, e_d} = op_q[3] ? de - 16'd1 : de + 16'd1;
                2'd2: {h_d, l_d} = op_q[3] ? hl - 16'd1 : hl + 16'd1;
                default: sp_d = op_q[3] ? sp_q - 16'd1 : sp_q + 16'd1;
              endcase
            end
            3'd4, 3'd5: begin
              mres = (lo == 3'd4) ? rsel(mid, b_q, c_q, d_q, e_q, h_q, l_q, a_q, t0_q) + 8'd1
                                  : rsel(mid, b_q, c_q, d_q, e_q, h_q, l_q, a_q, t0_q) - 8'd1;
              f_d = szp(f_q, mres); mwr = 1'b1;
            end
            3'd6: begin mres = b1_q; mwr = 1'b1; pc_d = pc_q + 16'd2; end
            default: begin
              case (mid)
                3'd0: begin f_d[FlCy] = a_q[7]; a_d = {a_q[6:0], a_q[7]}; end
                3'd1: begin f_d[FlCy] = a_q[0]; a_d = {a_q[0], a_q[7:1]}; end
                3'd2: begin f_d[FlCy] = a_q[7]; a_d = {a_q[6:0], f_q[FlCy]}; end
                3'd3: begin f_d[FlCy] = a_q[0]; a_d = {a_q[7], a_q[7:1]}; end
                3'd4: ;
                3'd5: a_d = ~a_q;
                3'd6: f_d[FlCy] = 1'b1;
                default: f_d[FlCy] = ~f_q[FlCy];
              endcase
            end
          endcase
        end else begin
          unique case (lo)
            3'd0: if (ccond) begin pc_d = {t1_q, t0_q}; sp_d = sp_q + 16'd2; end
            3'd1: begin
              if (op_q[3]) begin
                case (rp)
                  2'd0: begin pc_d = {t1_q, t0_q}; sp_d = sp_q + 16'd2; end
                  2'd2: pc_d = hl;
                  2'd3: sp_d = hl;
                  default: ;
                endcase
              end else begin
                sp_d = sp_q + 16'd2;
                case (rp)
                  2'd0: begin b_d = t1_q; c_d = t0_q; end
                  2'd1: begin d_d = t1_q; e_d = t0_q; end
                  2'd2: begin h_d = t1_q; l_d = t0_q; end
                  default: begin a_d = t1_q; f_d = t0_q & 8'hd5; end
                endcase
              end
            end
            3'd2: pc_d = ccond ? imm : pc_q + 16'd3;
            3'd3: begin
              case (mid)
                3'd0: pc_d = imm;
                3'd2, 3'd3: begin pc_d = pc_q; st_d = ST_UNIMPL; end
                3'd4: begin l_d = t0_q; h_d = t1_q; end
                3'd5: begin d_d = h_q; e_d = l_q; h_d = d_q; l_d = e_q; end
                3'd6: ie_d = 1'b0;
                3'd7: ie_d = 1'b1;
                default: ;
              endcase
            end
            3'd4: begin
              pc_d = pc_q + 16'd3;
              if (ccond) begin pc_d = imm; sp_d = sp_q - 16'd2; end
            end
            3'd5: begin
              if (is_push) sp_d = sp_q - 16'd2;
              if (op_q[3] && rp == 2'd0) pc_d = imm;
            end
            3'd6: begin
              if (wr_a) a_d = alu_res;
              f_d = fl; pc_d = pc_q + 16'd2;
            end
            default: begin sp_d = sp_q - 16'd2; pc_d = {10'd0, mid, 3'd0}; end
          endcase
        end
        if (mwr) begin
          case (mid)
            3'd0: b_d = mres; 3'd1: c_d = mres; 3'd2: d_d = mres; 3'd3: e_d = mres;
            3'd4: h_d = mres; 3'd5: l_d = mres;
            3'd6: req = '{we: 1'b1, addr: ma(hl), wdata: mres};
            default: a_d = mres;
          endcase
        end
        state_d = S_DONE;
      end
      default: begin
        done_d = 1'b1;
        if (hlt_q) st_d = ST_HALTED;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q <= 8'h00; b_q <= 8'h00; c_q <= 8'h00; d_q <= 8'h00;
      e_q <= 8'h00; h_q <= 8'h00; l_q <= 8'h00; f_q <= 8'h00;
      pc_q <= 16'd0; sp_q <= 16'd0; ie_q <= 1'b0; hlt_q <= 1'b0;
      step_q <= 3'd0; kind_q <= 2'd0; done_q <= 1'b0; st_q <= ST_OK; act_q <= ACT_WRITE;
    end else begin
      state_q <= state_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
      e_q <= e_d; h_q <= h_d; l_q <= l_d; f_q <= f_d;
      pc_q <= pc_d; sp_q <= sp_d; ie_q <= ie_d; hlt_q <= hlt_d;
      step_q <= step_d; kind_q <= kind_d; done_q <= done_d; st_q <= st_d; act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; b1_q <= b1_d; b2_q <= b2_d;
    irq_q <= irq_d; rd_q <= rd_d; t0_q <= t0_d; t1_q <= t1_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = st_q;
  assign read_data_o     = rd_q;
  assign prog_counter_o  = pc_q;
  assign stack_pointer_o = sp_q;
  assign accum_o         = a_q;
  assign pair_bc_o       = bc;
  assign pair_de_o       = de;
  assign pair_hl_o       = hl;
  assign flag_byte_o     = (f_q & 8'hd5) | 8'h02;
  assign irq_enabled_o   = ie_q;
endmodule
`default_nettype wire

@@ rtl/i8080_checker.sv @@
// Port-level checks for the 8080-style executor, bound to the top level.
// Depends on cpu_8080_instruction_executor.
`timescale 1ns / 1ps
`default_nettype none
module i8080_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       done_o,
  input wire logic [1:0] status_o,
  input wire logic [7:0] flag_byte_o
);
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("transfer while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("command not taken");
  a_flag_bit1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> flag_byte_o[1] && !flag_byte_o[3] && !flag_byte_o[5])
    else $error("flag byte layout");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status");
endmodule

bind cpu_8080_instruction_executor i8080_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .status_o(status_o), .flag_byte_o(flag_byte_o)
);
`default_nettype wire
